### src/gts_pkg.sv
// ----------------------------------------------------------------------------
// gts_pkg: shared types and constants of the generation tagged slot table
// Transaction payload structs, per-slot entry layout and operation codes.
// ----------------------------------------------------------------------------
package gts_pkg;

   // Operand width of the shared adder: 32-bit counts plus a signed delta,
   // with room for a second subtraction against the data-cluster limit.
   localparam int ALU_W = 35;

   localparam logic [31:0] GEN_MAX    = 32'hffff_ffff;
   localparam logic [31:0] FIRST_HINT = 32'd2;

   typedef enum logic [2:0] {
      OP_MOUNT    = 3'd0,
      OP_UNMOUNT  = 3'd1,
      OP_SET_HINT = 3'd2,
      OP_PUBLISH  = 3'd3,
      OP_ADJUST   = 3'd4,
      OP_QUERY    = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      STATUS_OK      = 3'd0,
      STATUS_STALE   = 3'd1,
      STATUS_INVALID = 3'd2,
      STATUS_CORRUPT = 3'd3,
      STATUS_NOSLOT  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      MODE_FREE    = 2'd0,
      MODE_LIVE    = 2'd1,
      MODE_RETIRED = 2'd2
   } mode_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic [63:0]        handle;
      logic [31:0]        hint_limit;
      logic [31:0]        cluster_total;
      logic [31:0]        value;
      logic signed [31:0] delta;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] new_handle;
      logic [31:0] hint_out;
      logic        free_known;
      logic [31:0] free_out;
   } rsp_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] generation;
      logic [31:0] alloc_hint;
      logic [31:0] free_count;
      logic        count_valid;
      logic [31:0] limit_store;
      logic [31:0] data_store;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      mode:        MODE_FREE,
      generation:  32'd0,
      alloc_hint:  32'd0,
      free_count:  32'd0,
      count_valid: 1'b0,
      limit_store: 32'd0,
      data_store:  32'd0
   };

endpackage

### src/generation_tagged_slot_table_top.sv
// ----------------------------------------------------------------------------
// generation_tagged_slot_table_top: generational volume handle table
// Slot table with per-slot generation counts, handle checking and
// free-cluster bookkeeping, run by a small sequencer around one adder.
// ----------------------------------------------------------------------------
// An unknown operation, a zero or out-of-range slot field or a zero generation
// is answered in the cycle after acceptance, with no table read; other handle
// operations pass through READ and EVAL, an adjust of a known count also ADJ.
// A mount runs READ and EVAL per slot up to the first usable free slot or the last.
// One transaction at a time; the next one is accepted from the
// cycle of the result strobe on. The receiver cannot stall. Reset is synchronous.
// ----------------------------------------------------------------------------
module generation_tagged_slot_table_top #(
   parameter int SLOT_COUNT = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gts_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output gts_pkg::rsp_type rsp_payload
);

   import gts_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   // One-hot sequencer. READ presents the slot address to the RAM, EVAL
   // checks and updates the slot, ADJ runs the second adder pass of an adjust.
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_EVAL = 4'b0100,
      S_ADJ  = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [SLOT_COUNT-1:0]  written_ff, written_in;
   logic                   rd_written_ff, rd_written_in;
   entry_type              slot_ff, slot_in;
   logic signed [ALU_W-1:0] adj_ff, adj_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;

   logic                   ram_we;
   entry_type              ram_wdata;
   logic [$bits(entry_type)-1:0] ram_rdata_raw;
   entry_type              cur;
   entry_type              upd;

   logic signed [ALU_W-1:0] alu_a, alu_b, alu_sum;
   logic [IDX_W-1:0]       enc_m1;
   logic                   advance;

   // The slot table itself. Mode and generation live next to the per-volume
   // fields so a mount scan needs a single read per slot.
   gts_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOT_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata_raw)
   );

   // A slot never written since reset reads as free with generation zero;
   // the written bits are the only per-slot flops that reset clears.
   assign cur = rd_written_ff ? entry_type'(ram_rdata_raw) : ENTRY_RESET;

   function automatic rsp_type show_slot(status_type st, logic [63:0] nh, entry_type e);
      rsp_type r;
      r.status     = st;
      r.new_handle = nh;
      r.hint_out   = e.alloc_hint;
      r.free_known = e.count_valid;
      r.free_out   = e.free_count;
      return r;
   endfunction

   function automatic rsp_type blank(status_type st);
      rsp_type r;
      r            = '0;
      r.status     = st;
      return r;
   endfunction

   // Shared adder. Its operands depend on the step: generation increment for
   // a mount, value against limit for a hint, value against data clusters for
   // a publish, count plus delta for an adjust and then the range check of
   // that sum against data clusters.
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      if (state_ff == S_ADJ) begin
         alu_a = $signed({{(ALU_W-32){1'b0}}, slot_ff.data_store});
         alu_b = -adj_ff;
      end else begin
         case (req_ff.operation)
            OP_MOUNT: begin
               alu_a = $signed({{(ALU_W-32){1'b0}}, cur.generation});
               alu_b = ALU_W'(1);
            end
            OP_SET_HINT: begin
               alu_a = $signed({{(ALU_W-32){1'b0}}, req_ff.value});
               alu_b = -$signed({{(ALU_W-32){1'b0}}, cur.limit_store});
            end
            OP_PUBLISH: begin
               alu_a = $signed({{(ALU_W-32){1'b0}}, cur.data_store});
               alu_b = -$signed({{(ALU_W-32){1'b0}}, req_ff.value});
            end
            OP_ADJUST: begin
               alu_a = $signed({{(ALU_W-32){1'b0}}, cur.free_count});
               alu_b = $signed({{(ALU_W-32){req_ff.delta[31]}}, req_ff.delta});
            end
            default: begin
               alu_a = '0;
               alu_b = '0;
            end
         endcase
      end
      alu_sum = alu_a + alu_b;
   end

   // The slot field is known to lie in 1..SLOT_COUNT when this is used, so
   // its low bits minus one give the slot index.
   assign enc_m1 = req_payload.handle[IDX_W-1:0] - IDX_W'(1);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      written_in    = written_ff;
      rd_written_in = rd_written_ff;
      slot_in       = slot_ff;
      adj_in        = adj_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      ram_we        = 1'b0;
      upd           = cur;
      advance       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_payload;
               unique case (req_payload.operation) inside
                  OP_MOUNT: begin
                     idx_in   = '0;
                     state_in = S_READ;
                  end
                  OP_UNMOUNT, OP_SET_HINT, OP_PUBLISH, OP_ADJUST, OP_QUERY: begin
                     // The slot field and the generation are checked before
                     // the table is touched.
                     if (req_payload.handle[31:0] == 32'd0 ||
                         req_payload.handle[31:0] > 32'(SLOT_COUNT) ||
                         req_payload.handle[63:32] == 32'd0) begin
                        rsp_in        = blank(STATUS_STALE);
                        rsp_strobe_in = 1'b1;
                     end else begin
                        idx_in   = enc_m1;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     rsp_in        = blank(STATUS_INVALID);
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         S_READ: begin
            rd_written_in = written_ff[idx_ff];
            state_in      = S_EVAL;
         end

         S_EVAL: begin
            slot_in = cur;
            if (req_ff.operation == OP_MOUNT) begin
               if (cur.mode != MODE_FREE) begin
                  advance = 1'b1;
               end else if (alu_sum[32]) begin
                  // Generation cannot grow any further: retire the slot.
                  upd.mode = MODE_RETIRED;
                  ram_we   = 1'b1;
                  advance  = 1'b1;
               end else begin
                  upd.mode        = MODE_LIVE;
                  upd.generation  = alu_sum[31:0];
                  upd.alloc_hint  = FIRST_HINT;
                  upd.free_count  = 32'd0;
                  upd.count_valid = 1'b0;
                  upd.limit_store = req_ff.hint_limit;
                  upd.data_store  = req_ff.cluster_total;
                  ram_we          = 1'b1;
                  rsp_in          = show_slot(STATUS_OK,
                     {alu_sum[31:0], {{(32-IDX_W){1'b0}}, idx_ff} + 32'd1}, upd);
                  rsp_strobe_in   = 1'b1;
                  state_in        = S_IDLE;
               end
               if (advance) begin
                  if (idx_ff == LAST_IDX) begin
                     rsp_in        = blank(STATUS_NOSLOT);
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_READ;
                  end
               end
            end else if (cur.mode != MODE_LIVE ||
                         cur.generation != req_ff.handle[63:32]) begin
               rsp_in        = blank(STATUS_STALE);
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
               rsp_in        = show_slot(STATUS_OK, 64'd0, cur);
               case (req_ff.operation)
                  OP_UNMOUNT: begin
                     // The generation is kept so old handles stay stale.
                     upd.mode = MODE_FREE;
                     ram_we   = 1'b1;
                     rsp_in   = show_slot(STATUS_OK, 64'd0, upd);
                  end
                  OP_SET_HINT: begin
                     // A negative sum means the value lies below the limit.
                     if (req_ff.value < FIRST_HINT || !alu_sum[ALU_W-1]) begin
                        rsp_in = show_slot(STATUS_INVALID, 64'd0, cur);
                     end else begin
                        upd.alloc_hint = req_ff.value;
                        ram_we         = 1'b1;
                        rsp_in         = show_slot(STATUS_OK, 64'd0, upd);
                     end
                  end
                  OP_PUBLISH: begin
                     if (alu_sum[ALU_W-1]) begin
                        rsp_in = show_slot(STATUS_INVALID, 64'd0, cur);
                     end else begin
                        upd.free_count  = req_ff.value;
                        upd.count_valid = 1'b1;
                        ram_we          = 1'b1;
                        rsp_in          = show_slot(STATUS_OK, 64'd0, upd);
                     end
                  end
                  OP_ADJUST: begin
                     // With an unknown count the adjust is a no-op.
                     if (cur.count_valid) begin
                        adj_in        = alu_sum;
                        rsp_strobe_in = 1'b0;
                        state_in      = S_ADJ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_ADJ: begin
            upd    = slot_ff;
            ram_we = 1'b1;
            // Out of range below zero or above the data clusters: the count
            // becomes unknown and keeps its old value.
            if (adj_ff[ALU_W-1] || alu_sum[ALU_W-1]) begin
               upd.count_valid = 1'b0;
               rsp_in          = show_slot(STATUS_CORRUPT, 64'd0, upd);
            end else begin
               upd.free_count = adj_ff[31:0];
               rsp_in         = show_slot(STATUS_OK, 64'd0, upd);
            end
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (ram_we) begin
         written_in[idx_ff] = 1'b1;
      end
   end

   assign ram_wdata = upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         written_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         written_ff    <= written_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      rd_written_ff <= rd_written_in;
      slot_ff       <= slot_in;
      adj_ff        <= adj_in;
      rsp_ff        <= rsp_in;
   end

   // Busy also covers the reset cycle so no transaction is taken then.
   assign busy        = reset || (state_ff != S_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

### src/gts_ram.sv
// ----------------------------------------------------------------------------
// gts_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module gts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                            clock,
   input  logic                                            wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                                wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/gts_checker.sv
// ----------------------------------------------------------------------------
// gts_checker: port-level assertions for the slot table
// Checks result contents and sequencing against accepted transactions.
// ----------------------------------------------------------------------------
module gts_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input gts_pkg::req_type req_payload,
   input logic             rsp_strobe,
   input gts_pkg::rsp_type rsp_payload
);

   import gts_pkg::*;

   // An unknown operation is answered at once with an invalid status.
   a_unknown_op: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.operation > OP_QUERY)
      |=> (rsp_strobe && rsp_payload.status == STATUS_INVALID))
      else $error("unknown operation not rejected in the next cycle");

   // A mount always reads the table, so it never answers at once.
   a_mount_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.operation == OP_MOUNT) |=> (busy && !rsp_strobe))
      else $error("mount answered without a table scan");

   // A handle is only issued by a successful mount, and then it is well formed.
   a_handle_issue: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.new_handle != 64'd0) |->
      (rsp_payload.status == STATUS_OK && rsp_payload.new_handle[31:0] != 32'd0 &&
       rsp_payload.new_handle[63:32] != 32'd0))
      else $error("malformed or unexpected new handle");

   // Unresolved handles and failed mounts show no slot contents.
   a_blank_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_payload.status == STATUS_STALE ||
                      rsp_payload.status == STATUS_NOSLOT)) |->
      (rsp_payload.hint_out == 32'd0 && !rsp_payload.free_known &&
       rsp_payload.free_out == 32'd0 && rsp_payload.new_handle == 64'd0))
      else $error("slot fields shown for an unresolved transaction");

endmodule

bind generation_tagged_slot_table_top gts_checker u_gts_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the generation tagged slot table
// Sends mount, unmount, hint, publish, adjust and query transactions, keeps
// a behavioral copy of the slot table to predict every result, and compares
// each result strobe field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   import gts_pkg::*;

   localparam int SLOTS       = 8;
   localparam int ITEMS       = 1950;
   localparam int CYCLE_LIMIT = 400000;
   // In this window no random idle gaps are drawn; only the halfway drain falls inside it.
   localparam int QUIET_FROM  = 700;
   localparam int QUIET_TO    = 1000;

   // The scoreboard owns a copy of the table state. Each accepted request is
   // run through the copy at once, so that the prediction sees the table
   // exactly as the block does, and the outcome waits in a queue until the
   // matching result strobe arrives.
   class slot_table_scoreboard;
      mode_type    slot_mode[SLOTS];
      logic [31:0] slot_gen[SLOTS];
      logic [31:0] hint[SLOTS];
      logic [31:0] free_cnt[SLOTS];
      logic        cnt_known[SLOTS];
      logic [31:0] limit[SLOTS];
      logic [31:0] data[SLOTS];
      rsp_type     pending_replies[$];
      int          mismatches;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            slot_mode[i] = MODE_FREE;
            slot_gen[i]  = '0;
            hint[i]      = '0;
            free_cnt[i]  = '0;
            cnt_known[i] = 1'b0;
            limit[i]     = '0;
            data[i]      = '0;
         end
         mismatches = 0;
      endfunction

      function rsp_type table_outcome(req_type r);
         rsp_type     o;
         logic [31:0] slot_field;
         logic [31:0] gen;
         int          idx;
         longint      step;
         longint      total;
         o = '0;
         if (r.operation > OP_QUERY) begin
            o.status = STATUS_INVALID;
            return o;
         end
         if (r.operation == OP_MOUNT) begin
            // First free slot wins; a free slot stuck at the top generation
            // is retired on the way and never comes back.
            o.status = STATUS_NOSLOT;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_mode[i] == MODE_FREE && slot_gen[i] == GEN_MAX) begin
                  slot_mode[i] = MODE_RETIRED;
               end else if (slot_mode[i] == MODE_FREE) begin
                  slot_gen[i]  = slot_gen[i] + 1;
                  hint[i]      = FIRST_HINT;
                  free_cnt[i]  = '0;
                  cnt_known[i] = 1'b0;
                  limit[i]     = r.hint_limit;
                  data[i]      = r.cluster_total;
                  slot_mode[i] = MODE_LIVE;
                  o.status     = STATUS_OK;
                  o.new_handle = {slot_gen[i], 32'(i + 1)};
                  o.hint_out   = hint[i];
                  o.free_known = cnt_known[i];
                  o.free_out   = free_cnt[i];
                  return o;
               end
            end
            return o;
         end
         slot_field = r.handle[31:0];
         gen        = r.handle[63:32];
         if (slot_field == 0 || slot_field > SLOTS || gen == 0) begin
            o.status = STATUS_STALE;
            return o;
         end
         idx = int'(slot_field) - 1;
         if (slot_mode[idx] != MODE_LIVE || slot_gen[idx] != gen) begin
            o.status = STATUS_STALE;
            return o;
         end
         case (r.operation)
            OP_UNMOUNT: begin
               slot_mode[idx] = MODE_FREE;
            end
            OP_SET_HINT: begin
               if (r.value < FIRST_HINT || r.value >= limit[idx]) begin
                  o.status = STATUS_INVALID;
               end else begin
                  hint[idx] = r.value;
               end
            end
            OP_PUBLISH: begin
               if (r.value > data[idx]) begin
                  o.status = STATUS_INVALID;
               end else begin
                  free_cnt[idx]  = r.value;
                  cnt_known[idx] = 1'b1;
               end
            end
            OP_ADJUST: begin
               // An unknown count is left alone; otherwise the sum is taken
               // wide enough that under- and overflow are both visible.
               if (cnt_known[idx]) begin
                  step  = {{32{r.delta[31]}}, r.delta};
                  total = longint'({32'd0, free_cnt[idx]}) + step;
                  if (total < 0 || total > longint'({32'd0, data[idx]})) begin
                     cnt_known[idx] = 1'b0;
                     o.status       = STATUS_CORRUPT;
                  end else begin
                     free_cnt[idx] = total[31:0];
                  end
               end
            end
            default: begin
            end
         endcase
         o.hint_out   = hint[idx];
         o.free_known = cnt_known[idx];
         o.free_out   = free_cnt[idx];
         return o;
      endfunction

      function void note_request(req_type r);
         pending_replies.push_back(table_outcome(r));
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_replies.size() == 0) begin
            $display("%0t: result with none outstanding, expected none, actual %h",
                     $time, got);
            mismatches++;
            return;
         end
         want = pending_replies.pop_front();
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("new_handle", want.new_handle, got.new_handle);
         compare_field("hint_out", 64'(want.hint_out), 64'(got.hint_out));
         compare_field("free_known", 64'(want.free_known), 64'(got.free_known));
         compare_field("free_out", 64'(want.free_out), 64'(got.free_out));
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   slot_table_scoreboard sb;
   int                   sent = 0;
   int unsigned          cycles = 0;

   generation_tagged_slot_table_top #(
      .SLOT_COUNT(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog. A healthy run ends before this limit, even with every mount
   // scanning the whole table and every idle gap at its longest.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // The receiver never stalls: every strobe is a result that must be
   // checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         sb.check_response(rsp_payload);
      end
   end

   // Presents one transaction and holds it until the block takes it. The
   // request is handed to the scoreboard by this task itself, so that the
   // next request is built on the table state that includes this one.
   // After acceptance the sender sometimes drops start and idles for a random
   // gap, except inside the quiet window.
   task automatic send_request(req_type r);
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(r);
      sent++;
      if ((sent < QUIET_FROM || sent > QUIET_TO) && $urandom_range(0, 99) < 32) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every predicted result has come back.
   task automatic wait_drained();
      start <= 1'b0;
      while (sb.pending_replies.size() != 0) @(posedge clock);
   endtask

   function automatic req_type make_req(logic [2:0] op, logic [63:0] h, logic [31:0] lim,
                                        logic [31:0] dat, logic [31:0] val,
                                        logic [31:0] dlt);
      req_type r;
      r.operation     = op;
      r.handle        = h;
      r.hint_limit    = lim;
      r.cluster_total = dat;
      r.value         = val;
      r.delta         = dlt;
      return r;
   endfunction

   // Picks a live slot at random, or returns -1 when nothing is mounted.
   function automatic int pick_live();
      int live[$];
      for (int i = 0; i < SLOTS; i++) begin
         if (sb.slot_mode[i] == MODE_LIVE) live.push_back(i);
      end
      if (live.size() == 0) return -1;
      return live[$urandom_range(0, live.size() - 1)];
   endfunction

   // Cluster counts are mostly small so that hints and free counts land
   // near their bounds; now and then a full 32-bit value goes in.
   function automatic logic [31:0] some_size();
      if ($urandom_range(0, 99) < 70) return $urandom_range(0, 100);
      return $urandom;
   endfunction

   // A handle that should fail the check: slot field zero, slot field past
   // the table, generation zero, a generation that does not match, a slot
   // that is not live, or plain noise.
   function automatic logic [63:0] broken_handle();
      int idx;
      idx = $urandom_range(0, SLOTS - 1);
      case ($urandom_range(0, 4))
         0: return {32'($urandom), 32'd0};
         1: return {32'($urandom), 32'($urandom_range(SLOTS + 1, 32'hffff_ffff))};
         2: return {32'd0, 32'(idx + 1)};
         3: begin
            if (sb.slot_mode[idx] != MODE_LIVE) return {sb.slot_gen[idx], 32'(idx + 1)};
            return {sb.slot_gen[idx] ^ (32'd1 << $urandom_range(0, 31)), 32'(idx + 1)};
         end
         default: return {32'($urandom), 32'($urandom)};
      endcase
   endfunction

   // Mostly mounts and well-formed traffic on live handles, with values aimed at the
   // range checks; the rest is stale handles and unknown operations. Fields
   // that an operation ignores carry random bits.
   function automatic req_type random_request();
      req_type     r;
      int          pick;
      int          idx;
      logic [31:0] lim;
      logic [31:0] dat;
      logic [31:0] cnt;
      r = make_req(OP_QUERY, {32'($urandom), 32'($urandom)}, $urandom, $urandom,
                   $urandom, $urandom);
      pick = $urandom_range(0, 99);
      idx  = pick_live();
      if (pick >= 94) begin
         r.operation = 3'($urandom_range(6, 7));
         return r;
      end
      if (pick >= 82) begin
         r.operation = 3'($urandom_range(OP_UNMOUNT, OP_QUERY));
         r.handle    = broken_handle();
         return r;
      end
      if (pick < 12 || idx < 0) begin
         r.operation     = OP_MOUNT;
         r.hint_limit    = some_size();
         r.cluster_total = some_size();
         return r;
      end
      r.handle = {sb.slot_gen[idx], 32'(idx + 1)};
      lim      = sb.limit[idx];
      dat      = sb.data[idx];
      cnt      = sb.free_cnt[idx];
      if (pick < 22) begin
         r.operation = OP_UNMOUNT;
      end else if (pick < 37) begin
         r.operation = OP_SET_HINT;
         case ($urandom_range(0, 3))
            0: r.value = $urandom_range(0, 3);
            1: r.value = lim - $urandom_range(0, 1);
            2: r.value = (lim > FIRST_HINT) ? $urandom_range(FIRST_HINT, lim - 1) : lim;
            default: begin
            end
         endcase
      end else if (pick < 51 || (pick < 70 && !sb.cnt_known[idx] && $urandom_range(0, 1))) begin
         // A count has to be published before adjusts do anything.
         r.operation = OP_PUBLISH;
         case ($urandom_range(0, 3))
            0: r.value = $urandom_range(0, dat);
            1: r.value = dat;
            2: r.value = dat + 1;
            default: begin
            end
         endcase
      end else if (pick < 70) begin
         r.operation = OP_ADJUST;
         case ($urandom_range(0, 5))
            0: r.delta = 32'($urandom_range(0, 20)) - 32'd10;
            1: r.delta = dat - cnt;
            2: r.delta = dat - cnt + 1;
            3: r.delta = -cnt;
            4: r.delta = -cnt - 1;
            default: begin
            end
         endcase
      end
      return r;
   endfunction

   // Directed opening. After reset the first mount lands in slot 1 with
   // generation 1 and the second in slot 2, so the handles are known.
   task automatic run_directed();
      logic [63:0] slot1;
      logic [63:0] slot2;
      slot1 = {32'd1, 32'd1};
      slot2 = {32'd1, 32'd2};
      // Empty table: slot field zero, then generation zero.
      send_request(make_req(OP_QUERY, 64'd0, '0, '0, '0, '0));
      send_request(make_req(OP_UNMOUNT, {32'd0, 32'd1}, '0, '0, '0, '0));
      // One volume at the widest limits and one at zero limits.
      send_request(make_req(OP_MOUNT, '1, '1, '1, '0, '0));
      send_request(make_req(OP_MOUNT, '0, '0, '0, '1, '1));
      // Hint range: empty range, below the first hint, top legal, at limit.
      send_request(make_req(OP_SET_HINT, slot2, '0, '0, 32'd2, '0));
      send_request(make_req(OP_SET_HINT, slot1, '0, '0, 32'd1, '0));
      send_request(make_req(OP_SET_HINT, slot1, '0, '0, 32'hffff_fffe, '0));
      send_request(make_req(OP_SET_HINT, slot1, '0, '0, 32'hffff_ffff, '0));
      // Adjust with no count published yet does nothing.
      send_request(make_req(OP_ADJUST, slot1, '0, '0, '0, 32'd5));
      // Publish at the data limit, above it, and zero on the empty volume.
      send_request(make_req(OP_PUBLISH, slot1, '0, '0, 32'hffff_ffff, '0));
      send_request(make_req(OP_PUBLISH, slot2, '0, '0, 32'd1, '0));
      send_request(make_req(OP_PUBLISH, slot2, '0, '0, 32'd0, '0));
      // Most negative and most positive deltas, then overflow past the limit.
      send_request(make_req(OP_ADJUST, slot1, '0, '0, '0, 32'h8000_0000));
      send_request(make_req(OP_ADJUST, slot1, '0, '0, '0, 32'h7fff_ffff));
      send_request(make_req(OP_ADJUST, slot1, '0, '0, '0, 32'd2));
      send_request(make_req(OP_QUERY, slot1, '0, '0, '0, '0));
      // Underflow below zero.
      send_request(make_req(OP_ADJUST, slot2, '0, '0, '0, 32'hffff_ffff));
      // Slot field past the table, and a generation that does not match.
      send_request(make_req(OP_QUERY, {32'd1, 32'd9}, '0, '0, '0, '0));
      send_request(make_req(OP_QUERY, {32'd2, 32'd1}, '0, '0, '0, '0));
      // Unmount, the old handle goes stale, a remount reuses the slot.
      send_request(make_req(OP_UNMOUNT, slot1, '0, '0, '0, '0));
      send_request(make_req(OP_QUERY, slot1, '0, '0, '0, '0));
      send_request(make_req(OP_MOUNT, '1, 32'd50, 32'd40, '1, '1));
      // Unknown operations.
      send_request(make_req(3'd6, '1, '1, '1, '1, '1));
      send_request(make_req(3'd7, '0, '0, '0, '0, '0));
   endtask

   // A slot is retired only once its generation has reached the maximum,
   // which takes about four billion mounts of that slot; the stimulus can
   // not get there, so the retire path is checked only by the predictor
   // agreeing that it never happens.
   initial begin
      sb          = new();
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      wait_drained();
      while (sent < ITEMS) begin
         // Halfway through, let the pipeline drain completely once more.
         if (sent == ITEMS / 2) wait_drained();
         send_request(random_request());
      end
      wait_drained();
      // The slowest transaction, a full mount scan, finishes well inside this.
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
